/* rtl/dgv_pkg.sv */
// ----------------------------------------------------------------------------
// dgv_pkg
// Shared types, constants and a saturation helper for the double-gyre
// velocity pipeline.
// ----------------------------------------------------------------------------
package dgv_pkg;

	localparam int ANG_W = 35;
	localparam int ATAN_ENTRIES = 30;

	typedef logic signed [31:0] word_t;
	typedef logic signed [ANG_W-1:0] angle_t;

	typedef enum logic [1:0] {
		REG_FLOW_AMPLITUDE,
		REG_OSCILLATION_RATE,
		REG_PERTURBATION_STRENGTH
	} reg_idx_t;

	localparam angle_t PI_Q29 = 35'sd1686629713;
	localparam angle_t HALF_PI_Q29 = 35'sd843314857;
	localparam angle_t TWO_PI_Q29 = 35'sd3373259426;
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
	localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

	localparam logic signed [31:0] ATAN_Q29 [ATAN_ENTRIES] = '{
		32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762580,
		32'sd33510843, 32'sd16771758, 32'sd8387925, 32'sd4194219,
		32'sd2097141, 32'sd1048575, 32'sd524288, 32'sd262144, 32'sd131072,
		32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048,
		32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16,
		32'sd8, 32'sd4, 32'sd2, 32'sd1
	};

	function automatic word_t sat32(input logic signed [63:0] v);
		if (v > 64'sh000000007FFFFFFF) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sh0000000080000000) begin
			return -32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

/* rtl/double_gyre_velocity_field.sv */
// ----------------------------------------------------------------------------
// double_gyre_velocity_field
// Velocity of the time-periodic double-gyre flow in signed fixed point.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   time_value, position_x, position_y
//   out      output     out_valid / out_ready velocity_x, velocity_y
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One item enters per cycle while in_ready is high. The stage count is fixed
// by the modulo reduction of omega*t (three subtract steps per stage) and by
// two CORDIC pipelines in series of min(CORDIC_STEPS,30)+2 stages each; with
// the default parameters there are 62 stages.
// Reset clears all valid bits and loads the register defaults.
// A stall at the output only freezes stages holding items; empty stages
// still fill, so the input keeps accepting until the pipeline is full.
// ----------------------------------------------------------------------------
module double_gyre_velocity_field
	import dgv_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_STEPS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  word_t       time_value,
	input  word_t       position_x,
	input  word_t       position_y,
	output logic        out_valid,
	input  logic        out_ready,
	output word_t       velocity_x,
	output word_t       velocity_y,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int NC = NS + 2;

	localparam logic [127:0] MOD_M =
		(128'(TWO_PI_Q60) + (128'd1 << (59 - 2 * FRAC_BITS))) >> (60 - 2 * FRAC_BITS);
	localparam logic [127:0] MOD_C =
		((128'd1 << 63) + MOD_M - 128'd1) / MOD_M * MOD_M;
	localparam int MW = $clog2(MOD_M + 128'd1);
	localparam int KMAX = 65 - MW;
	localparam int NK = 66 - MW;
	localparam int MOD_PER = 3;
	localparam int MOD_STG = (NK + MOD_PER - 1) / MOD_PER;
	localparam logic [65:0] M66 = MOD_M[65:0];
	localparam logic [65:0] C66 = MOD_C[65:0];

	localparam int S_OFS = 1;
	localparam int S_ANG = MOD_STG + 2;
	localparam int CA0 = S_ANG + 1;
	localparam int S_E1 = CA0 + NC;
	localparam int S_E2 = S_E1 + 1;
	localparam int S_E3 = S_E1 + 2;
	localparam int S_E4 = S_E1 + 3;
	localparam int S_PH = S_E1 + 4;
	localparam int S_M1 = S_PH + NC + 1;
	localparam int S_M2 = S_M1 + 1;
	localparam int S_M3 = S_M1 + 2;
	localparam int N = S_M3 + 1;

	function automatic word_t qmul(input word_t a, input word_t b);
		logic signed [63:0] pr;
		pr = 64'(a) * 64'(b);
		return sat32((pr + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
	endfunction

	function automatic angle_t pi_phase(input word_t v);
		logic [63:0] pr;
		pr = 64'(v[FRAC_BITS:0]) * 64'(PI_Q29);
		return ANG_W'((pr + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	endfunction

	word_t amp_q, rate_q, eps_q, pa_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= 32'sd6554;
			rate_q <= 32'sd41175;
			eps_q <= 32'sd16384;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLOW_AMPLITUDE: amp_q <= cfg_data;
				REG_OSCILLATION_RATE: rate_q <= cfg_data;
				REG_PERTURBATION_STRENGTH: eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pa_q <= sat32((64'(amp_q) * 64'(PI_Q29) + (64'sd1 <<< 28)) >>> 29);
	end

	logic [N-1:0] v_q;
	logic [N-1:0] en;

	always_comb begin
		en[N-1] = !v_q[N-1] || out_ready;
		for (int i = N - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < N; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign out_valid = v_q[N-1];

	word_t x_d [0:S_PH-1];
	word_t y_d [0:S_PH-1];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_d[0] <= position_x;
			y_d[0] <= position_y;
		end
		for (int i = 1; i < S_PH; i++) begin
			if (en[i]) begin
				x_d[i] <= x_d[i-1];
				y_d[i] <= y_d[i-1];
			end
		end
	end

	logic signed [63:0] p_s0;
	logic [65:0] rem_s [0:MOD_STG];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s0 <= 64'(rate_q) * 64'(time_value);
		end
		if (en[S_OFS]) begin
			rem_s[0] <= 66'(p_s0) + C66;
		end
	end

	for (genvar s = 0; s < MOD_STG; s++) begin : g_mod
		logic [65:0] rn;
		always_comb begin
			rn = rem_s[s];
			for (int i = 0; i < MOD_PER; i++) begin
				if (s * MOD_PER + i < NK) begin
					if (rn >= (M66 << (KMAX - s * MOD_PER - i))) begin
						rn = rn - (M66 << (KMAX - s * MOD_PER - i));
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[S_OFS+1+s]) begin
				rem_s[s+1] <= rn;
			end
		end
	end

	angle_t ang_s;
	angle_t ang_next;
	logic [65:0] rfin;

	assign rfin = 66'(rem_s[MOD_STG][MW-1:0]);

	if (2 * FRAC_BITS >= 29) begin : g_ang_rnd
		assign ang_next = ANG_W'((rfin + (66'd1 << (2 * FRAC_BITS - 30)))
			>> (2 * FRAC_BITS - 29));
	end else begin : g_ang_shl
		assign ang_next = ANG_W'(rfin << (29 - 2 * FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (en[S_ANG]) begin
			ang_s <= ang_next;
		end
	end

	word_t sin_t;

	dgv_cordic #(.FRAC_BITS(FRAC_BITS), .STEPS(NS)) u_cordic_t (
		.clk    (clk),
		.en     (en[CA0 +: NC]),
		.angle  (ang_s),
		.sine   (sin_t),
		.cosine ()
	);

	word_t es_s1, xx_s1, es_s2, xx_s2, two_es_s2, a_s2;
	word_t fa_s3, fb_s3, fc_s3, a_s3, f_s4;
	word_t df_d [S_E4:S_M2];
	angle_t phf_s5, phy_s5;
	logic signed [63:0] two_es_w;

	assign two_es_w = 64'(es_s1) + 64'(es_s1);

	always_ff @(posedge clk) begin
		if (en[S_E1]) begin
			es_s1 <= qmul(eps_q, sin_t);
			xx_s1 <= qmul(x_d[S_E1-1], x_d[S_E1-1]);
		end
		if (en[S_E2]) begin
			es_s2 <= es_s1;
			xx_s2 <= xx_s1;
			two_es_s2 <= sat32(two_es_w);
			a_s2 <= sat32((64'sd1 <<< FRAC_BITS) - 64'(sat32(two_es_w)));
		end
		if (en[S_E3]) begin
			fa_s3 <= qmul(es_s2, xx_s2);
			fb_s3 <= qmul(a_s2, x_d[S_E3-1]);
			fc_s3 <= qmul(two_es_s2, x_d[S_E3-1]);
			a_s3 <= a_s2;
		end
		if (en[S_E4]) begin
			f_s4 <= sat32(64'(fa_s3) + 64'(fb_s3));
			df_d[S_E4] <= sat32(64'(fc_s3) + 64'(a_s3));
		end
		for (int i = S_E4 + 1; i <= S_M2; i++) begin
			if (en[i]) begin
				df_d[i] <= df_d[i-1];
			end
		end
		if (en[S_PH]) begin
			phf_s5 <= pi_phase(f_s4);
			phy_s5 <= pi_phase(y_d[S_PH-1]);
		end
	end

	word_t sin_f, cos_f, sin_y, cos_y;

	dgv_cordic #(.FRAC_BITS(FRAC_BITS), .STEPS(NS)) u_cordic_f (
		.clk    (clk),
		.en     (en[S_PH+1 +: NC]),
		.angle  (phf_s5),
		.sine   (sin_f),
		.cosine (cos_f)
	);

	dgv_cordic #(.FRAC_BITS(FRAC_BITS), .STEPS(NS)) u_cordic_y (
		.clk    (clk),
		.en     (en[S_PH+1 +: NC]),
		.angle  (phy_s5),
		.sine   (sin_y),
		.cosine (cos_y)
	);

	word_t t1_s6, t2_s6, cy_s6, sy_s6, u_s7, t3_s7;

	always_ff @(posedge clk) begin
		if (en[S_M1]) begin
			t1_s6 <= qmul(pa_q, sin_f);
			t2_s6 <= qmul(pa_q, cos_f);
			cy_s6 <= cos_y;
			sy_s6 <= sin_y;
		end
		if (en[S_M2]) begin
			u_s7 <= sat32(-64'(qmul(t1_s6, cy_s6)));
			t3_s7 <= qmul(t2_s6, sy_s6);
		end
		if (en[S_M3]) begin
			velocity_x <= u_s7;
			velocity_y <= qmul(t3_s7, df_d[S_M2]);
		end
	end

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_q[0])
		else $error("input blocked while first stage is empty");

	a_drain_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("output taken but input not ready");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_q[0])
		else $error("accepted item lost at first stage");

	a_cfg_amp: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_FLOW_AMPLITUDE |=> amp_q == $past(cfg_data))
		else $error("amplitude register write not taken");

endmodule

/* rtl/dgv_cordic.sv */
// ----------------------------------------------------------------------------
// dgv_cordic
// Pipelined rotation-mode CORDIC: quadrant fold, one rotation per stage,
// then rounding of the Q30 results into the field format.
// ----------------------------------------------------------------------------
module dgv_cordic
	import dgv_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int STEPS = 18
) (
	input  logic           clk,
	input  logic [STEPS+1:0] en,
	input  angle_t         angle,
	output word_t          sine,
	output word_t          cosine
);

	localparam int XW = 33;
	localparam int RS = 30 - FRAC_BITS;

	logic signed [31:0]   z_s   [0:STEPS];
	logic signed [XW-1:0] x_s   [0:STEPS];
	logic signed [XW-1:0] y_s   [0:STEPS];
	logic                 neg_s [0:STEPS];

	angle_t zf;
	logic   neg;

	always_comb begin
		zf = angle;
		neg = 1'b0;
		if (zf > PI_Q29) begin
			zf = zf - TWO_PI_Q29;
		end
		if (zf > HALF_PI_Q29) begin
			zf = zf - PI_Q29;
			neg = 1'b1;
		end else if (zf < -HALF_PI_Q29) begin
			zf = zf + PI_Q29;
			neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			z_s[0] <= zf[31:0];
			x_s[0] <= GAIN_Q30;
			y_s[0] <= '0;
			neg_s[0] <= neg;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				neg_s[i+1] <= neg_s[i];
				if (!z_s[i][31]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_Q29[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_Q29[i];
				end
			end
		end
	end

	logic signed [63:0] xo;
	logic signed [63:0] yo;

	always_comb begin
		xo = neg_s[STEPS] ? -64'(x_s[STEPS]) : 64'(x_s[STEPS]);
		yo = neg_s[STEPS] ? -64'(y_s[STEPS]) : 64'(y_s[STEPS]);
	end

	always_ff @(posedge clk) begin
		if (en[STEPS+1]) begin
			cosine <= sat32((xo + (64'sd1 <<< (RS - 1))) >>> RS);
			sine <= sat32((yo + (64'sd1 <<< (RS - 1))) >>> RS);
		end
	end

endmodule
